/* design/mcct_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Compare timer package
// Item types, action codes and the per-channel control bundle shared by the
// compare timer modules.
// ----------------------------------------------------------------------------
package mcct_pkg;

    localparam int ACTION_W   = 2;
    localparam int CHAN_W     = 3;
    localparam int TIME_W     = 16;
    localparam int FIRE_W     = 7;
    localparam int ERR_W      = 2;

    localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_TAKE    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_ADJUST  = 2'd3;

    localparam int ERR_TAKE_BIT    = 0;
    localparam int ERR_RELEASE_BIT = 1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAN_W-1:0]   channel;
        logic                pick_any;
        logic [TIME_W-1:0]   interval;
        logic                single_shot;
    } t_in_item;

    typedef struct packed {
        logic [FIRE_W-1:0] fire_mask;
        logic [CHAN_W-1:0] granted_channel;
        logic              ok;
        logic [ERR_W-1:0]  error_flags;
    } t_out_item;

    typedef struct packed {
        logic tick;
        logic take;
        logic release_ch;
        logic adjust;
    } t_chan_ctl;

endpackage
`default_nettype wire

/* design/mcct_channel.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Compare timer channel
// One compare channel: holds its compare value, period, mode and active flag,
// detects a match on a tick and reloads or releases itself.
// ----------------------------------------------------------------------------
module mcct_channel (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire mcct_pkg::t_chan_ctl         i_ctl,
    input  wire logic [mcct_pkg::TIME_W-1:0] i_count,
    input  wire logic [mcct_pkg::TIME_W-1:0] i_count_next,
    input  wire logic [mcct_pkg::TIME_W-1:0] i_interval,
    input  wire logic                        i_single,
    output logic                             o_active,
    output logic                             o_fire
);
    import mcct_pkg::*;

    logic              r_active;
    logic              r_single;
    logic [TIME_W-1:0] r_compare;
    logic [TIME_W-1:0] r_period;
    logic              n_active;
    logic              n_single;
    logic [TIME_W-1:0] n_compare;
    logic [TIME_W-1:0] n_period;
    logic              w_fire;

    assign w_fire = i_ctl.tick && r_active && (r_compare == i_count_next);

    always_comb begin
        n_active  = r_active;
        n_single  = r_single;
        n_compare = r_compare;
        n_period  = r_period;
        if (w_fire) begin
            n_compare = r_compare + r_period;
            if (r_single) begin
                n_active = 1'b0;
            end
        end
        if (i_ctl.take) begin
            n_active  = 1'b1;
            n_single  = i_single;
            n_period  = i_interval;
            n_compare = i_count + i_interval;
        end
        if (i_ctl.release_ch) begin
            n_active = 1'b0;
        end
        if (i_ctl.adjust && r_active) begin
            n_compare = r_compare + i_interval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_single  <= n_single;
        r_compare <= n_compare;
        r_period  <= n_period;
    end

    assign o_active = r_active;
    assign o_fire   = w_fire;

endmodule
`default_nettype wire

/* design/multi_channel_compare_timer_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Multi-channel compare timer
// A 16-bit counter, advanced by tick items, shared by a set of output compare channels,
// driven by one action per item: tick, take, release or adjust.
// ----------------------------------------------------------------------------
// Usage: each input item on i_item (i_valid / o_ready) carries one action.
// A tick advances the counter and reports in fire_mask every active channel
// whose compare value equals the new count; fired channels reload by their
// period and single-shot channels are released. A take claims a named channel
// or the first free shared channel; release frees one; adjust moves the
// compare value of an active channel. Each item gives exactly one result item
// on o_result (o_valid / i_ready), with the sticky error flags after it.
// An accepted item is held in an input register and is worked out
// combinationally into the result register, from which it is presented and
// can be taken when the receiver is ready. One item is taken every cycle
// while the receiver does not stall: the compare, reload and free-channel
// pick all settle within that single pass.
// When the receiver stalls, the result register holds and the input register
// keeps one further item, after which o_ready falls. Reset clears the counter,
// frees all channels, clears the error flags and empties both registers.
// ----------------------------------------------------------------------------
module multi_channel_compare_timer_unit #(
    parameter int CHANNELS             = 7,
    parameter int FIRST_SHARED_CHANNEL = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire mcct_pkg::t_in_item    i_item,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output mcct_pkg::t_out_item        o_result
);
    import mcct_pkg::*;

    logic                r_in_valid;
    t_in_item            r_in;
    logic                r_out_valid;
    t_out_item           r_out;
    logic [TIME_W-1:0]   r_count;
    logic [ERR_W-1:0]    r_errors;

    logic                w_proc;
    logic [TIME_W-1:0]   w_count_next;
    logic                w_is_tick;
    logic                w_is_take;
    logic                w_is_release;
    logic                w_is_adjust;
    logic [CHANNELS-1:0] w_sel;
    logic [CHANNELS-1:0] w_active;
    logic [CHANNELS-1:0] w_fire;
    logic [CHANNELS-1:0] w_free_shared;
    logic [CHANNELS-1:0] w_pick_vec;
    logic [CHANNELS-1:0] w_take_vec;
    logic                w_take_ok;
    logic                w_in_range;
    logic [CHAN_W-1:0]   w_granted;
    logic [FIRE_W-1:0]   w_fire7;
    logic [ERR_W-1:0]    n_errors;
    t_out_item           n_out;

    assign w_proc  = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_proc;

    always_comb begin
        w_is_tick    = 1'b0;
        w_is_take    = 1'b0;
        w_is_release = 1'b0;
        w_is_adjust  = 1'b0;
        unique case (r_in.action)
            ACT_TICK:    w_is_tick    = 1'b1;
            ACT_TAKE:    w_is_take    = 1'b1;
            ACT_RELEASE: w_is_release = 1'b1;
            ACT_ADJUST:  w_is_adjust  = 1'b1;
            default:     w_is_tick    = 1'b0;
        endcase
    end

    assign w_count_next = r_count + TIME_W'(1);

    for (genvar c = 0; c < CHANNELS; c++) begin : g_chan
        localparam logic [4:0] ChanIdx = 5'(c);
        t_chan_ctl w_ctl;

        assign w_sel[c]         = ({2'b00, r_in.channel} == ChanIdx);
        assign w_free_shared[c] = (c >= FIRST_SHARED_CHANNEL) && !w_active[c];

        assign w_ctl.tick       = w_proc && w_is_tick;
        assign w_ctl.take       = w_proc && w_take_vec[c];
        assign w_ctl.release_ch = w_proc && w_is_release && w_sel[c];
        assign w_ctl.adjust     = w_proc && w_is_adjust && w_sel[c];

        mcct_channel u_channel (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_count      (r_count),
            .i_count_next (w_count_next),
            .i_interval   (r_in.interval),
            .i_single     (r_in.single_shot),
            .o_active     (w_active[c]),
            .o_fire       (w_fire[c])
        );
    end

    for (genvar b = 0; b < FIRE_W; b++) begin : g_fire
        if (b < CHANNELS) begin : g_used
            assign w_fire7[b] = w_fire[b];
        end else begin : g_pad
            assign w_fire7[b] = 1'b0;
        end
    end

    assign w_pick_vec = w_free_shared & (~w_free_shared + CHANNELS'(1));
    assign w_take_vec = !w_is_take     ? '0 :
                        r_in.pick_any ? w_pick_vec : (w_sel & ~w_active);
    assign w_take_ok  = |w_take_vec;
    assign w_in_range = |w_sel;

    always_comb begin
        w_granted = '0;
        for (int c = 0; c < CHANNELS; c++) begin
            if (w_take_vec[c]) begin
                w_granted = w_granted | CHAN_W'(c);
            end
        end
    end

    always_comb begin
        n_errors = r_errors;
        if (w_is_take && !w_take_ok) begin
            n_errors[ERR_TAKE_BIT] = 1'b1;
        end
        if (w_is_release && !w_in_range) begin
            n_errors[ERR_RELEASE_BIT] = 1'b1;
        end
        n_out.fire_mask       = w_is_tick ? w_fire7 : '0;
        n_out.granted_channel = w_granted;
        n_out.ok              = (w_is_take && w_take_ok)
                              || (w_is_release && w_in_range)
                              || (w_is_adjust && |(w_sel & w_active));
        n_out.error_flags     = n_errors;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_errors    <= '0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_proc) begin
                r_out_valid <= 1'b1;
                r_errors    <= n_errors;
                if (w_is_tick) begin
                    r_count <= w_count_next;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (o_ready && i_valid) begin
            r_in <= i_item;
        end
        if (w_proc) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    a_take_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_proc |-> $onehot0(w_take_vec))
        else $error("More than one channel selected for a take.");

    a_errors_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_errors[ERR_TAKE_BIT] |=> r_errors[ERR_TAKE_BIT])
        else $error("Take error flag cleared without reset.");

    a_granted_active : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_take_ok) |=> ((w_active & $past(w_take_vec)) == $past(w_take_vec)))
        else $error("Granted channel is not active after a take.");

    a_tick_result : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && w_is_tick) |=> (!r_out.ok && r_out.granted_channel == '0))
        else $error("Tick produced an ok or a granted channel.");

    a_fire_on_tick : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && !w_is_tick) |=> (r_out.fire_mask == '0))
        else $error("Fire mask set by an action other than a tick.");

endmodule
`default_nettype wire
